// ===== rtl/cwoc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwoc_pkg
// Shared types, register indexes and helpers for the caseless word counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwoc_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_RAW_W  = 5;
  localparam int TOTAL_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic [LEN_RAW_W-1:0] LEN_RESET = 5'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       file_end;
  } cwoc_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] occurrence_total;
    logic               total_saturated;
  } cwoc_result_t;

  // ASCII upper case to lower case, everything else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/caseless_word_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// caseless_word_occurrence_counter
// Counts non-overlapping, ASCII case-insensitive occurrences of a word in a
// byte stream and reports the total at the end of each file.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the window/count update;
//   only a file-end byte waits, while the result register holds an untaken total.
// Result path: the file's last byte is held in the input register, and its total
//   is then loaded into the result register, which drives m_axis.
// Reset: rst_ni clears the window fill, block and count, empties both registers,
//   zeroes the word and sets the length to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module caseless_word_occurrence_counter
  import cwoc_pkg::*;
#(
  parameter int MAX_PATTERN = 16,  // 1 to 16 word bytes
  parameter int COUNT_WIDTH = 32   // 8 to 32 bit running count
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // byte stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  wire logic                  s_axis_tuser,   // [0] chunk_start
  input  wire logic                  s_axis_tlast,   // file_end
  // file totals out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TOTAL_W-1:0]         m_axis_tdata,   // [31:0] occurrence_total
  output logic                       m_axis_tuser,   // [0] total_saturated
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MAX_PATTERN-1:0][7:0] pattern;
  logic [LEN_RAW_W-1:0]        length;
  cwoc_item_t                  in_item, work_item;
  cwoc_result_t                core_result, out_result;
  logic                        proc, out_free, res_load;

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.chunk_start = s_axis_tuser;
  assign in_item.file_end    = s_axis_tlast;

  // word bytes stored already folded, so only the stream side folds
  cwoc_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pattern_o  (pattern),
    .length_o   (length)
  );

  // bytes without file_end never wait on the result side
  cwoc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .out_free_i(out_free),
    .proc_o    (proc),
    .item_o    (work_item)
  );

  // shift window, compare all lengths in parallel, update block and count
  cwoc_core #(
    .MAX_PATTERN(MAX_PATTERN),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (proc),
    .item_i    (work_item),
    .pattern_i (pattern),
    .length_i  (length),
    .res_load_o(res_load),
    .result_o  (core_result)
  );

  cwoc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_load),
    .result_i   (core_result),
    .free_o     (out_free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .result_o   (out_result)
  );

  assign m_axis_tdata = out_result.occurrence_total;
  assign m_axis_tuser = out_result.total_saturated;

endmodule

`default_nettype wire

// ===== rtl/cwoc_cfg.sv =====
// ----------------------------------------------------------------------------
// cwoc_cfg
// Word and length registers; word bytes are case folded as they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module cwoc_cfg
  import cwoc_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  output logic      [MAX_PATTERN-1:0][7:0] pattern_o,
  output logic      [LEN_RAW_W-1:0]       length_o
);

  logic [MAX_PATTERN-1:0][7:0] pattern_q;
  logic [LEN_RAW_W-1:0]        length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW: begin
          for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < 8) begin
              pattern_q[i] <= fold_case(cfg_data_i[(i % 8) * 8 +: 8]);
            end
          end
        end
        CFG_PATTERN_HIGH: begin
          for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i >= 8) begin
              pattern_q[i] <= fold_case(cfg_data_i[(i % 8) * 8 +: 8]);
            end
          end
        end
        CFG_PATTERN_LENGTH: begin
          length_q <= cfg_data_i[LEN_RAW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign pattern_o = pattern_q;
  assign length_o  = length_q;

endmodule

`default_nettype wire

// ===== rtl/cwoc_in_reg.sv =====
// ----------------------------------------------------------------------------
// cwoc_in_reg
// Input register; releases an ordinary byte without waiting, and a file-end byte only when the result side can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module cwoc_in_reg
  import cwoc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire cwoc_item_t in_item_i,
  input  wire logic       out_free_i,
  output logic            proc_o,
  output cwoc_item_t      item_o
);

  logic       valid_q;
  cwoc_item_t item_q;
  logic       take;

  // a file-end byte needs room in the result register
  assign proc_o     = valid_q && (!item_q.file_end || out_free_i);
  assign in_ready_o = !valid_q || proc_o;
  assign take       = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (proc_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  held_until_processed : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_q && !proc_o |=> valid_q && item_q == $past(item_q))
    else $error("input register lost or changed a waiting byte");

endmodule

`default_nettype wire

// ===== rtl/cwoc_core.sv =====
// ----------------------------------------------------------------------------
// cwoc_core
// Match window, blocking counter and running count; one byte per cycle while proc_i is set.
// ----------------------------------------------------------------------------
`default_nettype none

module cwoc_core
  import cwoc_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        proc_i,
  input  wire cwoc_item_t                  item_i,
  input  wire logic [MAX_PATTERN-1:0][7:0] pattern_i,
  input  wire logic [LEN_RAW_W-1:0]        length_i,
  output logic                             res_load_o,
  output cwoc_result_t                     result_o
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int BLK_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

  logic [MAX_PATTERN-1:0][7:0] win_q, win_d;
  logic [FILL_W-1:0]           fill_q, fill_d, fill_base, fill_sh;
  logic [BLK_W-1:0]            blk_q, blk_d, blk_base;
  logic [COUNT_WIDTH-1:0]      count_q, count_d, count_upd;
  logic [FILL_W-1:0]           len_eff;
  logic [MAX_PATTERN-1:0]      hit_len;
  logic                        hit_sel, hit, cnt_sat;

  // length beyond the window is taken as the full window
  assign len_eff = (length_i > LEN_RAW_W'(MAX_PATTERN)) ? FILL_MAX : FILL_W'(length_i);

  // chunk start clears the window fill and the block before the byte enters
  assign fill_base = item_i.chunk_start ? '0 : fill_q;
  assign blk_base  = item_i.chunk_start ? '0 : blk_q;
  assign fill_sh   = (fill_base == FILL_MAX) ? fill_base : fill_base + 1'b1;

  always_comb begin
    win_d[0] = fold_case(item_i.data_byte);
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // one compare row per candidate length; newest byte is the word's last
  always_comb begin
    logic acc;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      acc = 1'b1;
      for (int i = 0; i < l; i++) begin
        acc = acc & (win_d[l-1-i] == pattern_i[i]);
      end
      hit_len[l-1] = acc;
    end
  end

  always_comb begin
    hit_sel = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (len_eff == FILL_W'(l)) begin
        hit_sel = hit_len[l-1];
      end
    end
  end

  assign cnt_sat = (count_q == '1);
  assign hit = (blk_base == '0) && (len_eff != '0) && (fill_sh >= len_eff) && hit_sel;

  always_comb begin
    count_upd = count_q;
    fill_d    = '0;
    blk_d     = '0;
    if (item_i.data_byte != 8'h00) begin
      fill_d = fill_sh;
      if (blk_base != '0) begin
        blk_d = blk_base - 1'b1;
      end else if (hit) begin
        blk_d = BLK_W'(len_eff - 1'b1);
        if (!cnt_sat) begin
          count_upd = count_q + 1'b1;
        end
      end
    end
    count_d = count_upd;
    if (item_i.file_end) begin
      count_d = '0;
      fill_d  = '0;
      blk_d   = '0;
    end
  end

  assign res_load_o                = proc_i && item_i.file_end;
  assign result_o.occurrence_total = TOTAL_W'(count_upd);
  assign result_o.total_saturated  = (count_upd == '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      blk_q   <= '0;
      count_q <= '0;
    end else if (proc_i) begin
      fill_q  <= fill_d;
      blk_q   <= blk_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i) begin
      win_q <= win_d;
    end
  end

  fresh_after_file : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    proc_i && item_i.file_end |=> count_q == '0 && fill_q == '0 && blk_q == '0)
    else $error("state not cleared after end of file");

  fill_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill beyond window depth");

  count_monotonic : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    proc_i && !item_i.file_end |=> count_q >= $past(count_q))
    else $error("count went down inside a file");

endmodule

`default_nettype wire

// ===== rtl/cwoc_out_reg.sv =====
// ----------------------------------------------------------------------------
// cwoc_out_reg
// Result register holding one file total until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cwoc_out_reg
  import cwoc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire cwoc_result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output cwoc_result_t      result_o
);

  logic         valid_q;
  cwoc_result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  no_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
